[rtl/cfra_pkg.sv]
// Shared constants for the continued fraction rational approximation block.
package cfra_pkg;

    // Parameter defaults.
    localparam int ORDER_LIMIT_DEF = 40;
    localparam int FRAC_BITS_DEF   = 32;
    localparam int INT_BITS_DEF    = 16;

    // Port widths.
    localparam int X_W   = 48;
    localparam int NUM_W = 48;
    localparam int DEN_W = 33;
    localparam int ERR_W = 32;
    localparam int ORD_W = 6;
    localparam int TOL_W = 32;

    // Tolerance after reset: 1.0e-8 in units of 2^-32.
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd43;

    // The radix-2 divider works on a dividend of this many bits.
    localparam int DIV_BITS = ERR_W + 1;
    localparam int CNT_W    = $clog2(DIV_BITS);

endpackage

[rtl/continued_fraction_rational_approx.sv]
// Top level: best rational approximation of a fixed-point value by continued fractions.
//
// The block reads x_value as an unsigned fixed-point number with INT_BITS integer bits
// over FRAC_BITS fraction bits and expands it as a continued fraction by exact integer
// Euclid steps. Each step forms the next convergent h/k, and the block stops at the
// first convergent whose error |x - h/k| is at or below the tolerance register (in
// units of 2^-32), or at order ORDER_LIMIT-1, whichever comes first. An input with a
// zero fraction returns its integer part over one at order 0. If the expansion ends
// early, the exact convergent is returned with zero error. The block takes one item at
// a time: in_ready is high only while it is idle, and the result sits in an output
// register, so a new beat is taken while the previous result still waits downstream.
// Operation: an integer input goes from idle straight to the finish state, which loads
// the output register. Otherwise every continued fraction order runs the shared
// radix-2 divider, which builds the convergent by shift-and-add from the same quotient
// bits, then an update state and a check state; the final error division and the
// output load follow. While an earlier result still waits in the output register, the
// block holds in its last state until that beat leaves.
// The tolerance register is written through cfg_we/cfg_wdata and must only be written
// while the block is idle.
module continued_fraction_rational_approx #(
    parameter int ORDER_LIMIT = cfra_pkg::ORDER_LIMIT_DEF,
    parameter int FRAC_BITS   = cfra_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS    = cfra_pkg::INT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cfra_pkg::TOL_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cfra_pkg::X_W-1:0]      x_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cfra_pkg::NUM_W-1:0]    numerator,
    output logic [cfra_pkg::DEN_W-1:0]    denominator,
    output logic [cfra_pkg::ERR_W-1:0]    achieved_error,
    output logic [cfra_pkg::ORD_W-1:0]    order_used,
    output logic                          tolerance_met
);
    import cfra_pkg::*;

    // Internal widths. Remainders and denominators never exceed 2^F, numerators
    // never exceed the input value, and tolerance*k stays below 2^(32+F).
    localparam int F          = FRAC_BITS;
    localparam int W          = INT_BITS + FRAC_BITS;
    localparam int PW         = F + 1;
    localparam int TW         = ERR_W + F + 1;
    localparam int LAST_ORDER = ORDER_LIMIT - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_UPDATE,
        S_CHECK,
        S_EDIV,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [TOL_W-1:0]    tol_reg, tol_next;

    // Euclid remainders and the two most recent convergents. The t registers track
    // tolerance*k with the same recurrence as k, so the stop test needs no multiplier.
    logic [PW-1:0]       rem_prev_reg, rem_prev_next;
    logic [PW-1:0]       rem_reg, rem_next;
    logic [W-1:0]        h_prev_reg, h_prev_next;
    logic [W-1:0]        h_reg, h_next;
    logic [PW-1:0]       k_prev_reg, k_prev_next;
    logic [PW-1:0]       k_reg, k_next;
    logic [TW-1:0]       t_prev_reg, t_prev_next;
    logic [TW-1:0]       t_reg, t_next;

    // Horner accumulators for a*h, a*k and a*t, fed MSB first by the quotient bits.
    logic [W-1:0]        hacc_reg, hacc_next;
    logic [PW-1:0]       kacc_reg, kacc_next;
    logic [TW-1:0]       tacc_reg, tacc_next;

    // Shared restoring divider.
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [PW-1:0]       part_reg, part_next;
    logic [PW-1:0]       dsr_reg, dsr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [ORD_W-1:0]    order_reg, order_next;
    logic                met_reg, met_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]    numerator_reg, numerator_next;
    logic [DEN_W-1:0]    denominator_reg, denominator_next;
    logic [ERR_W-1:0]    error_reg, error_next;
    logic [ORD_W-1:0]    order_out_reg, order_out_next;
    logic                met_out_reg, met_out_next;

    // Divider step and derived values.
    logic [PW:0]         trial;
    logic                qbit;
    logic [PW-1:0]       part_step;
    logic [DIV_BITS-1:0] quo_step;
    logic                div_last;
    logic [ERR_W-1:0]    scaled;
    logic                within_tol;
    logic [F-1:0]        x_frac;
    logic [INT_BITS-1:0] x_int;

    assign trial     = {part_reg, quo_reg[DIV_BITS-1]};
    assign qbit      = trial >= {1'b0, dsr_reg};
    assign part_step = qbit ? PW'(trial - {1'b0, dsr_reg}) : PW'(trial);
    assign quo_step  = {quo_reg[DIV_BITS-2:0], qbit};
    assign div_last  = (cnt_reg == CNT_W'(DIV_BITS - 1));

    // The error numerator |X*k - h*2^F| is the current remainder.
    assign scaled     = ERR_W'(rem_reg[F-1:0]) << (ERR_W - F);
    assign within_tol = TW'(scaled) <= t_reg;

    assign x_frac = x_value[F-1:0];
    assign x_int  = x_value[W-1:F];

    always_comb
    begin
        state_next       = state_reg;
        tol_next         = tol_reg;
        rem_prev_next    = rem_prev_reg;
        rem_next         = rem_reg;
        h_prev_next      = h_prev_reg;
        h_next           = h_reg;
        k_prev_next      = k_prev_reg;
        k_next           = k_reg;
        t_prev_next      = t_prev_reg;
        t_next           = t_reg;
        hacc_next        = hacc_reg;
        kacc_next        = kacc_reg;
        tacc_next        = tacc_reg;
        quo_next         = quo_reg;
        part_next        = part_reg;
        dsr_next         = dsr_reg;
        cnt_next         = cnt_reg;
        order_next       = order_reg;
        met_next         = met_reg;
        out_valid_next   = out_valid_reg;
        numerator_next   = numerator_reg;
        denominator_next = denominator_reg;
        error_next       = error_reg;
        order_out_next   = order_out_reg;
        met_out_next     = met_out_reg;

        if (cfg_we)
        begin
            tol_next = cfg_wdata;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rem_prev_next = PW'(1) << F;
                    rem_next      = PW'(x_frac);
                    h_prev_next   = W'(1);
                    h_next        = W'(x_int);
                    k_prev_next   = '0;
                    k_next        = PW'(1);
                    t_prev_next   = '0;
                    t_next        = TW'(tol_reg);
                    order_next    = '0;
                    part_next     = '0;
                    cnt_next      = '0;
                    hacc_next     = '0;
                    kacc_next     = '0;
                    tacc_next     = '0;
                    if (x_frac == '0)
                    begin
                        // Integer input: x/1 with zero error.
                        met_next   = 1'b1;
                        quo_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        quo_next   = DIV_BITS'(PW'(1) << F);
                        dsr_next   = PW'(x_frac);
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                part_next = part_step;
                quo_next  = quo_step;
                hacc_next = W'(hacc_reg << 1) + (qbit ? h_reg : '0);
                kacc_next = PW'(kacc_reg << 1) + (qbit ? k_reg : '0);
                tacc_next = TW'(tacc_reg << 1) + (qbit ? t_reg : '0);
                cnt_next  = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                h_prev_next   = h_reg;
                h_next        = hacc_reg + h_prev_reg;
                k_prev_next   = k_reg;
                k_next        = kacc_reg + k_prev_reg;
                t_prev_next   = t_reg;
                t_next        = tacc_reg + t_prev_reg;
                rem_prev_next = rem_reg;
                rem_next      = part_reg;
                order_next    = order_reg + ORD_W'(1);
                state_next    = S_CHECK;
            end

            S_CHECK:
            begin
                part_next = '0;
                cnt_next  = '0;
                if (within_tol || (order_reg == ORD_W'(LAST_ORDER)))
                begin
                    // A finished expansion has a zero remainder and always passes.
                    met_next   = within_tol;
                    quo_next   = DIV_BITS'(scaled);
                    dsr_next   = k_reg;
                    state_next = S_EDIV;
                end
                else
                begin
                    quo_next   = DIV_BITS'(rem_prev_reg);
                    dsr_next   = rem_reg;
                    hacc_next  = '0;
                    kacc_next  = '0;
                    tacc_next  = '0;
                    state_next = S_DIV;
                end
            end

            S_EDIV:
            begin
                part_next = part_step;
                quo_next  = quo_step;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    numerator_next   = NUM_W'(h_reg);
                    denominator_next = DEN_W'(k_reg);
                    error_next       = quo_reg[ERR_W-1:0];
                    order_out_next   = order_reg;
                    met_out_next     = met_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tol_reg         <= TOL_RESET;
            out_valid_reg   <= 1'b0;
            rem_prev_reg    <= '0;
            rem_reg         <= '0;
            h_prev_reg      <= '0;
            h_reg           <= '0;
            k_prev_reg      <= '0;
            k_reg           <= '0;
            t_prev_reg      <= '0;
            t_reg           <= '0;
            hacc_reg        <= '0;
            kacc_reg        <= '0;
            tacc_reg        <= '0;
            quo_reg         <= '0;
            part_reg        <= '0;
            dsr_reg         <= '0;
            cnt_reg         <= '0;
            order_reg       <= '0;
            met_reg         <= 1'b0;
            numerator_reg   <= '0;
            denominator_reg <= '0;
            error_reg       <= '0;
            order_out_reg   <= '0;
            met_out_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tol_reg         <= tol_next;
            out_valid_reg   <= out_valid_next;
            rem_prev_reg    <= rem_prev_next;
            rem_reg         <= rem_next;
            h_prev_reg      <= h_prev_next;
            h_reg           <= h_next;
            k_prev_reg      <= k_prev_next;
            k_reg           <= k_next;
            t_prev_reg      <= t_prev_next;
            t_reg           <= t_next;
            hacc_reg        <= hacc_next;
            kacc_reg        <= kacc_next;
            tacc_reg        <= tacc_next;
            quo_reg         <= quo_next;
            part_reg        <= part_next;
            dsr_reg         <= dsr_next;
            cnt_reg         <= cnt_next;
            order_reg       <= order_next;
            met_reg         <= met_next;
            numerator_reg   <= numerator_next;
            denominator_reg <= denominator_next;
            error_reg       <= error_next;
            order_out_reg   <= order_out_next;
            met_out_reg     <= met_out_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign numerator      = numerator_reg;
    assign denominator    = denominator_reg;
    assign achieved_error = error_reg;
    assign order_used     = order_out_reg;
    assign tolerance_met  = met_out_reg;

endmodule

[rtl/cfra_checker.sv]
// Port-level checker for the continued fraction approximation block, with its bind.
module cfra_checker #(
    parameter int ORDER_LIMIT = cfra_pkg::ORDER_LIMIT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [cfra_pkg::TOL_W-1:0]    cfg_wdata,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [cfra_pkg::X_W-1:0]      x_value,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [cfra_pkg::NUM_W-1:0]    numerator,
    input logic [cfra_pkg::DEN_W-1:0]    denominator,
    input logic [cfra_pkg::ERR_W-1:0]    achieved_error,
    input logic [cfra_pkg::ORD_W-1:0]    order_used,
    input logic                          tolerance_met
);
    import cfra_pkg::*;

    // Once a beat is taken, the block is busy with it on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // A result waiting downstream keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(numerator)
            && $stable(denominator) && $stable(achieved_error)))
        else $error("pending result changed");

    // An integer input gives an exact result over one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (order_used == '0)) |->
            (tolerance_met && (achieved_error == '0) && (denominator == DEN_W'(1))))
        else $error("order zero result is not an exact integer");

    // A missed tolerance can only come from the order limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tolerance_met) |->
            ((order_used == ORD_W'(ORDER_LIMIT - 1)) && (denominator != '0)))
        else $error("tolerance missed before the order limit");

endmodule

bind continued_fraction_rational_approx cfra_checker #(.ORDER_LIMIT(ORDER_LIMIT)) u_cfra_checker (.*);
